// ===== src/ean8_barcode_rasterizer_core_defines.svh =====
// assertion macros for the ean-8 rasterizer core
`ifndef EAN8_BARCODE_RASTERIZER_CORE_DEFINES_SVH
`define EAN8_BARCODE_RASTERIZER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define EAN8_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define EAN8_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define EAN8_ASSERT_IMP(label, ante, cons, msg)
`define EAN8_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// ===== src/ean8_pkg.sv =====
// types, code tables and module decode for the ean-8 rasterizer core
package ean8_pkg;

  localparam int unsigned MODULES   = 67;
  localparam int unsigned DIV_STEPS = 11;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_PIXEL = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    REG_SPACING      = 2'd0,
    REG_MODULE_WIDTH = 2'd1,
    REG_BAR_HEIGHT   = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic       is_digit;
    logic       guard;
    logic [2:0] slot;
    logic [2:0] offset;
  } mod_dec_t;

  // left-hand odd parity codes, msb is the leftmost module
  localparam logic [6:0] LEFT_CODE [10] = '{
    7'h0D, 7'h19, 7'h13, 7'h3D, 7'h23, 7'h31, 7'h2F, 7'h3B, 7'h37, 7'h0B
  };

  // 7x7 glyphs, one row per entry, msb is leftmost
  localparam logic [6:0] FONT [10][7] = '{
    '{7'h00, 7'h1C, 7'h22, 7'h22, 7'h22, 7'h22, 7'h1C},
    '{7'h00, 7'h08, 7'h18, 7'h08, 7'h08, 7'h08, 7'h1C},
    '{7'h00, 7'h1C, 7'h22, 7'h04, 7'h08, 7'h10, 7'h3E},
    '{7'h00, 7'h1C, 7'h22, 7'h04, 7'h0C, 7'h22, 7'h1C},
    '{7'h00, 7'h04, 7'h0C, 7'h14, 7'h3E, 7'h04, 7'h04},
    '{7'h00, 7'h3E, 7'h20, 7'h3C, 7'h02, 7'h22, 7'h1C},
    '{7'h00, 7'h1C, 7'h22, 7'h20, 7'h3C, 7'h22, 7'h1C},
    '{7'h00, 7'h3E, 7'h02, 7'h04, 7'h08, 7'h10, 7'h10},
    '{7'h00, 7'h1C, 7'h22, 7'h1C, 7'h22, 7'h22, 7'h1C},
    '{7'h00, 7'h1C, 7'h22, 7'h22, 7'h1E, 7'h02, 7'h1C}
  };

  // split a module offset inside a four-digit half into digit and position
  function automatic logic [4:0] split7(input logic [6:0] t);
    logic [1:0] s;
    logic [6:0] o;
    if (t >= 7'd21) begin
      s = 2'd3;
      o = t - 7'd21;
    end else if (t >= 7'd14) begin
      s = 2'd2;
      o = t - 7'd14;
    end else if (t >= 7'd7) begin
      s = 2'd1;
      o = t - 7'd7;
    end else begin
      s = 2'd0;
      o = t;
    end
    return {s, o[2:0]};
  endfunction

  function automatic mod_dec_t decode_module(input logic [6:0] m);
    mod_dec_t   d;
    logic [6:0] t;
    logic [4:0] sp;
    d = '0;
    t = '0;
    sp = '0;
    if (m < 7'd3) begin
      d.guard = (m != 7'd1);
    end else if (m < 7'd31) begin
      t = m - 7'd3;
      sp = split7(t);
      d.is_digit = 1'b1;
      d.slot = {1'b0, sp[4:3]};
      d.offset = sp[2:0];
    end else if (m < 7'd36) begin
      t = m - 7'd31;
      d.guard = (t == 7'd1) || (t == 7'd3);
    end else if (m < 7'd64) begin
      t = m - 7'd36;
      sp = split7(t);
      d.is_digit = 1'b1;
      d.slot = {1'b1, sp[4:3]};
      d.offset = sp[2:0];
    end else begin
      t = m - 7'd64;
      d.guard = (t != 7'd1);
    end
    return d;
  endfunction

  function automatic logic mult_of_ten(input logic [7:0] v);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < 26; k++) begin
      if (v == 8'(k * 10)) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

// ===== src/ean8_barcode_rasterizer_core.sv =====
// ean-8 barcode rasterizer: digit load, check digit, one pixel per word
//
//  channel  direction  handshake            payload
//  item     in         item_valid/stall     command, digit_0..digit_7
//  result   out        result_valid/stall   pixel, row_end, image_end, code_valid,
//                                           image_width, image_height
//  cfg      in         cfg_valid/ready      cfg_index, cfg_data
//
//  one word per cycle when not stalled; each result word comes in the next cycle
//  pixel position is kept as row/column counters plus module and font-row counters
//  after any cfg write the block stalls items in setup and divide while a serial
//  divider rebuilds the module and font-row counters from the row/column position
//  a held result stalls the item side only if the result side is stalled
//  rst is synchronous and restores the default spacing 4, module width 3, bar height 50
`include "ean8_barcode_rasterizer_core_defines.svh"

module ean8_barcode_rasterizer_core
  import ean8_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        command,
  input  logic [3:0]  digit_0,
  input  logic [3:0]  digit_1,
  input  logic [3:0]  digit_2,
  input  logic [3:0]  digit_3,
  input  logic [3:0]  digit_4,
  input  logic [3:0]  digit_5,
  input  logic [3:0]  digit_6,
  input  logic [3:0]  digit_7,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        pixel,
  output logic        row_end,
  output logic        image_end,
  output logic        code_valid,
  output logic [10:0] image_width,
  output logic [10:0] image_height,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV
  } state_t;

  state_t      state;
  logic [7:0]  spacing;
  logic [3:0]  module_width;
  logic [9:0]  bar_height;
  logic [3:0]  digits [8];
  logic        valid_flag;
  logic [10:0] col;
  logic [10:0] row;
  logic [6:0]  qc;
  logic [3:0]  rc;
  logic [2:0]  qr;
  logic [3:0]  rr;
  logic [10:0] dvd_c;
  logic [10:0] dvd_r;
  logic [3:0]  rem_c;
  logic [3:0]  rem_r;
  logic [3:0]  step_cnt;

  logic [3:0]  mw_eff;
  logic [10:0] img_w;
  logic [10:0] img_h;
  logic [10:0] row_thr;
  logic        busy;
  logic        accept;
  logic        cfg_write;

  logic        text;
  logic        in_image;
  logic [2:0]  frow;
  mod_dec_t    dec;
  logic [3:0]  dv;
  logic [6:0]  code;
  logic [2:0]  bitpos;
  logic        pix_val;

  logic [11:0] col_p1;
  logic [11:0] row_p1;
  logic        rend;
  logic        iend;
  logic [10:0] col_next;
  logic [10:0] row_next;
  logic [6:0]  qc_next;
  logic [3:0]  rc_next;
  logic [2:0]  qr_next;
  logic [3:0]  rr_next;

  logic [4:0]  sh_c;
  logic [4:0]  sh_r;
  logic        ge_c;
  logic        ge_r;
  logic [3:0]  rem_c_next;
  logic [3:0]  rem_r_next;
  logic [10:0] dvd_c_next;
  logic [10:0] dvd_r_next;

  logic [7:0]  check_sum;
  logic        digits_ok;
  logic        load_valid;

  assign mw_eff = (module_width == 4'd0) ? 4'd1 : module_width;
  assign img_w = 11'({spacing, 1'b0}) + 11'({mw_eff, 6'b0}) + 11'({mw_eff, 1'b0})
               + 11'(mw_eff);
  assign img_h = 11'(bar_height) + 11'({mw_eff, 3'b0}) - 11'(mw_eff)
               + 11'({spacing, 1'b0});
  assign row_thr = 11'(spacing) + 11'(bar_height);

  assign busy = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign item_stall = busy || (result_valid && result_stall);
  assign accept = item_valid && !item_stall;

  // pixel at the current position
  always_comb begin
    text = (row >= row_thr);
    in_image = (col >= 11'(spacing)) && (row >= 11'(spacing)) && (qc < 7'(MODULES))
             && !(text && (qr == 3'd7));
    frow = (qr == 3'd7) ? 3'd6 : qr;
    dec = decode_module(qc);
    dv = digits[dec.slot];
    bitpos = 3'd6 - dec.offset;
    code = '0;
    if (dv <= 4'd9) begin
      if (text) begin
        code = FONT[dv][frow];
      end else if (dec.slot[2]) begin
        code = ~LEFT_CODE[dv];
      end else begin
        code = LEFT_CODE[dv];
      end
    end
    pix_val = in_image && (dec.is_digit ? code[bitpos] : dec.guard);
  end

  // advance of the raster counters
  always_comb begin
    col_p1 = 12'(col) + 12'd1;
    row_p1 = 12'(row) + 12'd1;
    rend = (col_p1 >= 12'(img_w));
    iend = rend && (row_p1 >= 12'(img_h));
    col_next = col_p1[10:0];
    row_next = row;
    qc_next = qc;
    rc_next = rc;
    qr_next = qr;
    rr_next = rr;
    if (rend) begin
      col_next = '0;
      qc_next = '0;
      rc_next = '0;
      if (iend) begin
        row_next = '0;
        qr_next = '0;
        rr_next = '0;
      end else begin
        row_next = row_p1[10:0];
        if (row_p1 <= 12'(row_thr)) begin
          qr_next = '0;
          rr_next = '0;
        end else if (rr == mw_eff - 4'd1) begin
          rr_next = '0;
          qr_next = (qr == 3'd7) ? qr : qr + 3'd1;
        end else begin
          rr_next = rr + 4'd1;
        end
      end
    end else begin
      if (col_p1 <= 12'(spacing)) begin
        qc_next = '0;
        rc_next = '0;
      end else if (rc == mw_eff - 4'd1) begin
        rc_next = '0;
        qc_next = (qc == 7'd127) ? qc : qc + 7'd1;
      end else begin
        rc_next = rc + 4'd1;
      end
    end
  end

  // one restoring division step for column and row
  always_comb begin
    sh_c = {rem_c, dvd_c[10]};
    sh_r = {rem_r, dvd_r[10]};
    ge_c = (sh_c >= {1'b0, mw_eff});
    ge_r = (sh_r >= {1'b0, mw_eff});
    rem_c_next = ge_c ? 4'(sh_c - {1'b0, mw_eff}) : sh_c[3:0];
    rem_r_next = ge_r ? 4'(sh_r - {1'b0, mw_eff}) : sh_r[3:0];
    dvd_c_next = {dvd_c[9:0], ge_c};
    dvd_r_next = {dvd_r[9:0], ge_r};
  end

  // check digit
  always_comb begin
    check_sum = 8'({digit_0, 1'b0}) + 8'(digit_0) + 8'(digit_1)
              + 8'({digit_2, 1'b0}) + 8'(digit_2) + 8'(digit_3)
              + 8'({digit_4, 1'b0}) + 8'(digit_4) + 8'(digit_5)
              + 8'({digit_6, 1'b0}) + 8'(digit_6) + 8'(digit_7);
    digits_ok = (digit_0 <= 4'd9) && (digit_1 <= 4'd9) && (digit_2 <= 4'd9)
             && (digit_3 <= 4'd9) && (digit_4 <= 4'd9) && (digit_5 <= 4'd9)
             && (digit_6 <= 4'd9) && (digit_7 <= 4'd9);
    load_valid = digits_ok && mult_of_ten(check_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      spacing <= 8'd4;
      module_width <= 4'd3;
      bar_height <= 10'd50;
      for (int i = 0; i < 8; i++) digits[i] <= '0;
      valid_flag <= 1'b0;
      col <= '0;
      row <= '0;
      qc <= '0;
      rc <= '0;
      qr <= '0;
      rr <= '0;
      step_cnt <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_SPACING:      spacing <= cfg_data[7:0];
          REG_MODULE_WIDTH: module_width <= cfg_data[3:0];
          REG_BAR_HEIGHT:   bar_height <= cfg_data;
          default: ;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (cfg_write) state <= ST_SETUP;
        end
        ST_SETUP: begin
          dvd_c <= (col >= 11'(spacing)) ? col - 11'(spacing) : '0;
          dvd_r <= (row >= row_thr) ? row - row_thr : '0;
          rem_c <= '0;
          rem_r <= '0;
          step_cnt <= '0;
          state <= cfg_write ? ST_SETUP : ST_DIV;
        end
        ST_DIV: begin
          dvd_c <= dvd_c_next;
          dvd_r <= dvd_r_next;
          rem_c <= rem_c_next;
          rem_r <= rem_r_next;
          step_cnt <= step_cnt + 4'd1;
          if (cfg_write) begin
            state <= ST_SETUP;
          end else if (step_cnt == 4'(DIV_STEPS - 1)) begin
            qc <= (|dvd_c_next[10:7]) ? 7'd127 : dvd_c_next[6:0];
            rc <= rem_c_next;
            qr <= (|dvd_r_next[10:3]) ? 3'd7 : dvd_r_next[2:0];
            rr <= rem_r_next;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (accept) begin
        result_valid <= 1'b1;
        image_width <= img_w;
        image_height <= img_h;
        if (command == CMD_LOAD) begin
          digits[0] <= digit_0;
          digits[1] <= digit_1;
          digits[2] <= digit_2;
          digits[3] <= digit_3;
          digits[4] <= digit_4;
          digits[5] <= digit_5;
          digits[6] <= digit_6;
          digits[7] <= digit_7;
          valid_flag <= load_valid;
          col <= '0;
          row <= '0;
          qc <= '0;
          rc <= '0;
          qr <= '0;
          rr <= '0;
          pixel <= 1'b0;
          row_end <= 1'b0;
          image_end <= 1'b0;
          code_valid <= load_valid;
        end else begin
          col <= col_next;
          row <= row_next;
          qc <= qc_next;
          rc <= rc_next;
          qr <= qr_next;
          rr <= rr_next;
          pixel <= pix_val;
          row_end <= rend;
          image_end <= iend;
          code_valid <= valid_flag;
        end
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  `EAN8_ASSERT_IMP(a_sub_in_range, !busy, rc < mw_eff, "module subpixel out of range")
  `EAN8_ASSERT_IMP(a_border_zero, !busy && (col < 11'(spacing)), (qc == '0) && (rc == '0),
    "module counters not zero in the left border")
  `EAN8_ASSERT_NXT(a_load_result, accept && (command == CMD_LOAD),
    result_valid && !pixel && !row_end && !image_end, "load word has a pixel mark")
  `EAN8_ASSERT_IMP(a_image_end_row, result_valid && image_end, row_end,
    "image end without row end")
  `EAN8_ASSERT_NXT(a_cfg_rebuild, cfg_write, busy, "cfg write did not start rebuild")

endmodule
